// File: rtl/core/mbet_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel package
// Shared constants, command and status types, controller states and the
// saturation helper used by the escape-time datapath.
// ----------------------------------------------------------------------------
package mbet_pkg;

  // Frame and iteration constants.
  localparam int WIDTH     = 1024;
  localparam int HEIGHT    = 768;
  localparam int MAX_ITER  = 256;
  localparam int FRAC_BITS = 28;

  // Field widths.
  localparam int POS_W   = 10;
  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int LIMIT_W = 36;
  localparam int COUNT_W = 9;
  localparam int SHADE_W = 8;

  // Internal widths.
  localparam int ITER_W  = $clog2(MAX_ITER + 1);
  localparam int TWICE_W = 14;
  localparam int MAP_W   = TWICE_W + COORD_W;
  localparam int PROD_W  = 2 * COORD_W;
  localparam int LEVEL_W = 8;
  localparam int SQ_W    = 2 * LEVEL_W;
  localparam int BIT_W   = $clog2(LEVEL_W);

  // Shade level I is floor(sqrt(SHADE_SCALE * N / MAX_ITER)).
  localparam longint SHADE_SCALE = 65025;
  localparam int     CMP_W       = $clog2(64'(SHADE_SCALE) * 64'(MAX_ITER)) + 1;
  localparam logic [SHADE_W-1:0] SHADE_NONE = 8'd0;
  localparam logic [SHADE_W-1:0] SHADE_LOW  = 8'd64;
  localparam logic [SHADE_W-1:0] SHADE_HIGH = 8'd192;

  // Saturation bounds of a coordinate.
  localparam longint COORD_MAX = (64'sd1 <<< (COORD_W - 1)) - 64'sd1;
  localparam longint COORD_MIN = -(64'sd1 <<< (COORD_W - 1));

  // Configuration port.
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 64;

  typedef enum logic [1:0] {
    REG_CENTER_RE,
    REG_CENTER_IM,
    REG_PIXEL_STEP,
    REG_ESCAPE_LIMIT
  } reg_index_e;

  localparam logic signed [COORD_W-1:0] CENTER_RE_RST    = -32'sd134217728;
  localparam logic signed [COORD_W-1:0] CENTER_IM_RST    = 32'sd0;
  localparam logic [STEP_W-1:0]         PIXEL_STEP_RST   = 31'd786432;
  localparam logic [LIMIT_W-1:0]        ESCAPE_LIMIT_RST = 36'd26843545600;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_MUL,
    ST_MAP_ADD,
    ST_IT_MUL,
    ST_IT_UPD,
    ST_SHADE_LIM,
    ST_SHADE_SQ,
    ST_SHADE_CMP,
    ST_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic map_mul;
    logic map_add;
    logic it_mul;
    logic it_upd;
    logic shade_init;
    logic shade_sq;
    logic shade_cmp;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_max;
    logic escape;
    logic bit_last;
  } dp_status_t;

  function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [63:0] v);
    logic signed [COORD_W-1:0] r;
    if (v > COORD_MAX) begin
      r = COORD_W'(COORD_MAX);
    end else if (v < COORD_MIN) begin
      r = COORD_W'(COORD_MIN);
    end else begin
      r = v[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/mbet_dp.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time datapath
// Pixel mapping, the z = z*z + c iteration with escape test, the bit-serial
// square root for the shade level and the result register.
// ----------------------------------------------------------------------------
module mbet_dp (
  input  logic                                  clk_i,
  input  logic signed [mbet_pkg::COORD_W-1:0]   center_re_i,
  input  logic signed [mbet_pkg::COORD_W-1:0]   center_im_i,
  input  logic        [mbet_pkg::STEP_W-1:0]    pixel_step_i,
  input  logic        [mbet_pkg::LIMIT_W-1:0]   escape_limit_i,
  input  logic        [mbet_pkg::POS_W-1:0]     pixel_x_i,
  input  logic        [mbet_pkg::POS_W-1:0]     pixel_y_i,
  input  mbet_pkg::dp_cmd_t                     cmd_i,
  output mbet_pkg::dp_status_t                  status_o,
  output logic        [mbet_pkg::POS_W-1:0]     out_x_o,
  output logic        [mbet_pkg::POS_W-1:0]     out_y_o,
  output logic        [mbet_pkg::COUNT_W-1:0]   iter_count_o,
  output logic                                  in_set_o,
  output logic        [mbet_pkg::SHADE_W-1:0]   shade_o
);
  import mbet_pkg::*;

  logic        [POS_W-1:0]   held_x_q, held_y_q;
  logic signed [MAP_W-1:0]   prod_x_q, prod_y_q, prod_x_d, prod_y_d;
  logic signed [COORD_W-1:0] c_re_q, c_im_q, c_re_d, c_im_d;
  logic signed [COORD_W-1:0] z_re_q, z_im_q, z_re_d, z_im_d;
  logic        [ITER_W-1:0]  n_q;
  logic signed [PROD_W-1:0]  x2_q, y2_q, xy_q, x2_d, y2_d, xy_d;
  logic        [CMP_W-1:0]   lim_q, lim_d;
  logic        [LEVEL_W-1:0] level_q, trial;
  logic        [BIT_W-1:0]   bit_q;
  logic        [SQ_W-1:0]    sq_q, sq_d;

  logic signed [TWICE_W-1:0] tw_x, tw_y;
  logic signed [COORD_W-1:0] step_s;
  logic        [PROD_W-1:0]  r2;
  logic signed [PROD_W-1:0]  diff;
  logic                      escape, keep, in_set_w;
  logic        [SHADE_W-1:0] shade_w;

  // Mapping: offsets are kept doubled so odd frame sizes stay exact.
  always_comb begin
    tw_x     = $signed(TWICE_W'({held_x_q, 1'b0})) - $signed(TWICE_W'(WIDTH));
    tw_y     = $signed(TWICE_W'({held_y_q, 1'b0})) - $signed(TWICE_W'(HEIGHT));
    step_s   = $signed({1'b0, pixel_step_i});
    prod_x_d = MAP_W'(tw_x) * MAP_W'(step_s);
    prod_y_d = MAP_W'(tw_y) * MAP_W'(step_s);
    c_re_d   = sat_coord(64'(prod_x_q >>> 1) + 64'(center_re_i));
    c_im_d   = sat_coord(64'(prod_y_q >>> 1) + 64'(center_im_i));
  end

  // Iteration: the products are registered, then the escape test and update use them.
  always_comb begin
    x2_d   = z_re_q * z_re_q;
    y2_d   = z_im_q * z_im_q;
    xy_d   = z_re_q * z_im_q;
    r2     = $unsigned(x2_q) + $unsigned(y2_q);
    escape = (r2 >> FRAC_BITS) >= PROD_W'(escape_limit_i);
    diff   = x2_q - y2_q;
    z_re_d = sat_coord(64'(diff >>> FRAC_BITS) + 64'(c_re_q));
    z_im_d = sat_coord(64'(xy_q >>> (FRAC_BITS - 1)) + 64'(c_im_q));
  end

  // Shade level: restoring square root, one result bit per square-and-compare step.
  always_comb begin
    lim_d    = CMP_W'(n_q) * CMP_W'(SHADE_SCALE);
    trial    = level_q | (LEVEL_W'(1) << bit_q);
    sq_d     = SQ_W'(trial) * SQ_W'(trial);
    keep     = (CMP_W'(sq_q) * CMP_W'(MAX_ITER)) <= lim_q;
    in_set_w = (n_q == ITER_W'(MAX_ITER));
    if (in_set_w || !level_q[0]) begin
      shade_w = SHADE_NONE;
    end else if (level_q[LEVEL_W-1]) begin
      shade_w = SHADE_HIGH;
    end else begin
      shade_w = SHADE_LOW;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      held_x_q <= pixel_x_i;
      held_y_q <= pixel_y_i;
    end
    if (cmd_i.map_mul) begin
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
    if (cmd_i.map_add) begin
      c_re_q <= c_re_d;
      c_im_q <= c_im_d;
      z_re_q <= c_re_d;
      z_im_q <= c_im_d;
      n_q    <= '0;
    end
    if (cmd_i.it_mul) begin
      x2_q <= x2_d;
      y2_q <= y2_d;
      xy_q <= xy_d;
    end
    if (cmd_i.it_upd) begin
      z_re_q <= z_re_d;
      z_im_q <= z_im_d;
      n_q    <= n_q + ITER_W'(1);
    end
    if (cmd_i.shade_init) begin
      lim_q   <= lim_d;
      level_q <= '0;
      bit_q   <= BIT_W'(LEVEL_W - 1);
    end
    if (cmd_i.shade_sq) begin
      sq_q <= sq_d;
    end
    if (cmd_i.shade_cmp) begin
      if (keep) begin
        level_q <= trial;
      end
      bit_q <= bit_q - BIT_W'(1);
    end
    if (cmd_i.out_load) begin
      out_x_o      <= held_x_q;
      out_y_o      <= held_y_q;
      iter_count_o <= COUNT_W'(n_q);
      in_set_o     <= in_set_w;
      shade_o      <= shade_w;
    end
  end

  always_comb begin
    status_o.iter_max = in_set_w;
    status_o.escape   = escape;
    status_o.bit_last = (bit_q == '0);
  end

endmodule

// File: rtl/core/mbet_ctrl.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time controller
// Sequences mapping, iteration, shading and result hand-off, and keeps the
// valid flag of the result register.
// ----------------------------------------------------------------------------
module mbet_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  input  mbet_pkg::dp_status_t  status_i,
  output mbet_pkg::dp_cmd_t     cmd_o
);
  import mbet_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MAP_MUL;
        end
      end
      ST_MAP_MUL: begin
        cmd_o.map_mul = 1'b1;
        state_d       = ST_MAP_ADD;
      end
      ST_MAP_ADD: begin
        cmd_o.map_add = 1'b1;
        state_d       = ST_IT_MUL;
      end
      ST_IT_MUL: begin
        // The step limit is checked before the next squaring.
        if (status_i.iter_max) begin
          state_d = ST_RESULT;
        end else begin
          cmd_o.it_mul = 1'b1;
          state_d      = ST_IT_UPD;
        end
      end
      ST_IT_UPD: begin
        if (status_i.escape) begin
          state_d = ST_SHADE_LIM;
        end else begin
          cmd_o.it_upd = 1'b1;
          state_d      = ST_IT_MUL;
        end
      end
      ST_SHADE_LIM: begin
        cmd_o.shade_init = 1'b1;
        state_d          = ST_SHADE_SQ;
      end
      ST_SHADE_SQ: begin
        cmd_o.shade_sq = 1'b1;
        state_d        = ST_SHADE_CMP;
      end
      ST_SHADE_CMP: begin
        cmd_o.shade_cmp = 1'b1;
        state_d         = status_i.bit_last ? ST_RESULT : ST_SHADE_SQ;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/mandelbrot_escape_time_pixel_top.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time pixel engine
// Maps a pixel position to a point c and counts z = z*z + c steps to escape.
// ----------------------------------------------------------------------------
// The input stream carries one pixel position per transaction. The output
// stream returns the position, the step count N, the in-set flag (tuser) and
// the shade. The APB port holds the view centre, pixel step and escape limit;
// the user must write it only while no pixel is in flight (not enforced here).
//
// One pixel is worked on at a time. The time from the input transaction to a
// valid result depends on the step count N of the pixel; it is set by the
// datapath's iteration loop, which squares z and then does the escape test
// and update, and by the bit-serial square root of the shade level, which
// runs only for a pixel that escapes. The next pixel can be taken in the
// cycle after the result is loaded.
//
// A finished result sits in the output register; the next pixel is accepted
// while it waits. If the receiver stalls, the following result waits in the
// controller until the register frees. Reset loads the register defaults
// and leaves no result pending.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: pixel_x[9:0], pixel_y[19:10], zero fill.
  input  logic [23:0]                        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: out_x[9:0], out_y[19:10], iter_count[28:20],
  // shade[36:29], zero fill.
  output logic [39:0]                        m_axis_tdata,
  // Fields from bit 0: in_set[0].
  output logic                               m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mbet_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mbet_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mbet_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready
);
  import mbet_pkg::*;

  logic signed [COORD_W-1:0] center_re_q, center_im_q;
  logic        [STEP_W-1:0]  pixel_step_q;
  logic        [LIMIT_W-1:0] escape_limit_q;
  reg_index_e                reg_sel;
  logic                      cfg_write;

  dp_cmd_t                   cmd;
  dp_status_t                status;
  logic        [POS_W-1:0]   out_x, out_y;
  logic        [COUNT_W-1:0] iter_count;
  logic                      in_set;
  logic        [SHADE_W-1:0] shade;

  assign pready    = 1'b1;
  assign reg_sel   = reg_index_e'(paddr[APB_ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q    <= CENTER_RE_RST;
      center_im_q    <= CENTER_IM_RST;
      pixel_step_q   <= PIXEL_STEP_RST;
      escape_limit_q <= ESCAPE_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_CENTER_RE:    center_re_q    <= pwdata[COORD_W-1:0];
        REG_CENTER_IM:    center_im_q    <= pwdata[COORD_W-1:0];
        REG_PIXEL_STEP:   pixel_step_q   <= pwdata[STEP_W-1:0];
        REG_ESCAPE_LIMIT: escape_limit_q <= pwdata[LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CENTER_RE:    prdata = APB_DATA_W'($unsigned(center_re_q));
      REG_CENTER_IM:    prdata = APB_DATA_W'($unsigned(center_im_q));
      REG_PIXEL_STEP:   prdata = APB_DATA_W'(pixel_step_q);
      REG_ESCAPE_LIMIT: prdata = APB_DATA_W'(escape_limit_q);
      default:          prdata = '0;
    endcase
  end

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mbet_dp u_dp (
    .clk_i          (clk_i),
    .center_re_i    (center_re_q),
    .center_im_i    (center_im_q),
    .pixel_step_i   (pixel_step_q),
    .escape_limit_i (escape_limit_q),
    .pixel_x_i      (s_axis_tdata[POS_W-1:0]),
    .pixel_y_i      (s_axis_tdata[2*POS_W-1:POS_W]),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .iter_count_o   (iter_count),
    .in_set_o       (in_set),
    .shade_o        (shade)
  );

  assign m_axis_tdata = {3'b000, shade, iter_count, out_y, out_x};
  assign m_axis_tuser = in_set;

  // A new pixel is not taken in the cycle after one was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted twice in a row");

  // The controller issues at most one datapath command per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

  // A result is never loaded over one that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending result overwritten");

  // A result leaves only after the controller has issued its load.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.out_load))
    else $error("output valid without a result load");

endmodule

// File: test/mandelbrot_escape_time_pixel_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time pixel engine testbench
// Sends pixel positions over the input stream, predicts each result (point
// mapping, saturated z*z + c loop, step count and shade) and checks every
// output transaction in order. The view registers are rewritten over APB
// between phases. The run starts with a short directed table and then
// continues with random views and pixels, with random stalls on both sides.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_pixel_top_tb;
  import mbet_pkg::*;

  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int RX_HOLD_CYCLES = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 100;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 2 * MAX_ITER + 40;
  localparam int DIRECTED_ROWS  = 29;

  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [COUNT_W-1:0] count;
    logic               in_set;
    logic [SHADE_W-1:0] shade;
  } pixel_result_t;

  typedef enum logic {ROW_REG, ROW_PIXEL} plan_kind_e;

  // A register row writes idx/value; a pixel row sends px/py and, when known
  // is set, checks against the typed count, in_set and shade.
  typedef struct packed {
    plan_kind_e         kind;
    reg_index_e         idx;
    logic [63:0]        value;
    logic [POS_W-1:0]   px;
    logic [POS_W-1:0]   py;
    logic               known;
    logic [COUNT_W-1:0] count;
    logic               in_set;
    logic [SHADE_W-1:0] shade;
  } plan_row_t;

  localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd1023, 10'd767, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd512, 10'd384, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd1023, 10'd1023, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd0, 10'd768, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    // A zero escape limit stops every pixel before its first step.
    '{ROW_REG, REG_ESCAPE_LIMIT, 64'd0, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd0, 10'd0, 1'b1, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd1023, 10'd1023, 1'b1, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd341, 10'd682, 1'b1, 9'd0, 1'b0, SHADE_NONE},
    // Zero step and zero centre pin c and z at the origin: never escapes.
    '{ROW_REG, REG_CENTER_RE, 64'd0, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_CENTER_IM, 64'd0, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_PIXEL_STEP, 64'd0, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_ESCAPE_LIMIT, 64'hF_FFFF_FFFF, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd5, 10'd7, 1'b1, 9'd256, 1'b1, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd1023, 10'd1023, 1'b1, 9'd256, 1'b1, SHADE_NONE},
    // Extreme centre and step drive the mapping into saturation.
    '{ROW_REG, REG_CENTER_RE, 64'h8000_0000, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_CENTER_IM, 64'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_PIXEL_STEP, 64'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd1023, 10'd1023, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_ESCAPE_LIMIT, 64'd26843545600, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_CENTER_RE, 64'h7FFF_FFFF, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd1023, 10'd767, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    // Near the boundary of the set, where step counts spread out.
    '{ROW_REG, REG_PIXEL_STEP, 64'd786432, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_REG, REG_CENTER_RE, 64'hFFFF_FFFF_F400_0000, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0,
      SHADE_NONE},
    '{ROW_REG, REG_CENTER_IM, 64'd26843546, 10'd0, 10'd0, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd600, 10'd300, 1'b0, 9'd0, 1'b0, SHADE_NONE},
    '{ROW_PIXEL, REG_CENTER_RE, 64'd0, 10'd0, 10'd767, 1'b0, 9'd0, 1'b0, SHADE_NONE}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [39:0]           m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // View registers as the engine should hold them.
  logic signed [COORD_W-1:0] view_re;
  logic signed [COORD_W-1:0] view_im;
  logic [STEP_W-1:0]         view_step;
  logic [LIMIT_W-1:0]        view_limit;

  pixel_result_t pending_pixels[$];
  int            mismatch_count;
  int unsigned   cycle_count;
  logic          tx_gaps;
  logic          rx_gaps;
  logic          rx_hold_req;

  mandelbrot_escape_time_pixel_top i_dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp_coord(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // The offset is taken in half pixels so an odd frame size stays exact.
  function automatic longint map_coord(int pos, longint size, logic signed [COORD_W-1:0] centre);
    longint offs2;
    longint prod;
    offs2 = 2 * longint'(pos) - size;
    prod  = offs2 * longint'({1'b0, view_step});
    return clamp_coord((prod >>> 1) + longint'(centre));
  endfunction

  function automatic pixel_result_t predict_escape(logic [POS_W-1:0] px, logic [POS_W-1:0] py);
    pixel_result_t r;
    longint        c_re, c_im, z_re, z_im;
    longint        sq_re, sq_im, sq_xy, lim;
    logic [63:0]   mag2;
    int            n;
    int            level;
    c_re  = map_coord(int'(px), longint'(WIDTH), view_re);
    c_im  = map_coord(int'(py), longint'(HEIGHT), view_im);
    z_re  = c_re;
    z_im  = c_im;
    n     = 0;
    while (n < MAX_ITER) begin
      sq_re = z_re * z_re;
      sq_im = z_im * z_im;
      sq_xy = z_re * z_im;
      mag2  = sq_re + sq_im;
      if ((mag2 >> FRAC_BITS) >= 64'(view_limit)) break;
      z_re = clamp_coord(((sq_re - sq_im) >>> FRAC_BITS) + c_re);
      z_im = clamp_coord((sq_xy >>> (FRAC_BITS - 1)) + c_im);
      n++;
    end
    // Shade level is the integer square root of 65025 * N / MAX_ITER.
    level = 0;
    if (n < MAX_ITER) begin
      lim = 64'sd65025 * n;
      while (level < 255 && longint'((level + 1) * (level + 1) * MAX_ITER) <= lim) level++;
    end
    r.x      = px;
    r.y      = py;
    r.count  = COUNT_W'(n);
    r.in_set = (n >= MAX_ITER);
    r.shade  = SHADE_NONE;
    if (n < MAX_ITER && (level % 2) == 1) r.shade = (level >= 128) ? SHADE_HIGH : SHADE_LOW;
    return r;
  endfunction

  task automatic flag_error(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(reg_index_e idx, logic [63:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_CENTER_RE:    view_re    = value[COORD_W-1:0];
      REG_CENTER_IM:    view_im    = value[COORD_W-1:0];
      REG_PIXEL_STEP:   view_step  = value[STEP_W-1:0];
      REG_ESCAPE_LIMIT: view_limit = value[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // tvalid is left high after a transaction unless a random gap follows, so
  // back-to-back pixels need no second assignment in the same step.
  task automatic send_pixel(logic [POS_W-1:0] px, logic [POS_W-1:0] py, logic known,
                            pixel_result_t typed);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {4'b0000, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    if (known) pending_pixels.push_back(typed);
    else pending_pixels.push_back(predict_escape(px, py));
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic randomize_view();
    int          c;
    logic [63:0] v;
    c = int'($urandom_range(0, 671088640)) - 536870912;
    write_reg(REG_CENTER_RE, {{32{c[31]}}, c});
    c = int'($urandom_range(0, 644245094)) - 322122547;
    write_reg(REG_CENTER_IM, {{32{c[31]}}, c});
    case ($urandom_range(0, 3))
      0:       v = 64'($urandom_range(0, 4096));
      1:       v = 64'($urandom_range(100000, 1000000));
      2:       v = 64'(PIXEL_STEP_RST);
      default: v = 64'($urandom);
    endcase
    write_reg(REG_PIXEL_STEP, v);
    case ($urandom_range(0, 3))
      0:       v = 64'(ESCAPE_LIMIT_RST);
      1:       v = 64'h4000_0000;
      2:       v = 64'($urandom);
      default: v = {$urandom, $urandom};
    endcase
    write_reg(REG_ESCAPE_LIMIT, v);
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready = 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(negedge clk_i);
        rx_hold_req = 1'b0;
      end else if (rx_gaps && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    pixel_result_t got;
    pixel_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.x      = m_axis_tdata[9:0];
      got.y      = m_axis_tdata[19:10];
      got.count  = m_axis_tdata[28:20];
      got.shade  = m_axis_tdata[36:29];
      got.in_set = m_axis_tuser;
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected result x=%0d y=%0d count=%0d", got.x, got.y,
                             got.count));
      end else begin
        want = pending_pixels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.count !== want.count ||
            got.in_set !== want.in_set || got.shade !== want.shade) begin
          flag_error({
            $sformatf("mismatch: expected x=%0d y=%0d count=%0d in_set=%0d shade=%0d, ",
                      want.x, want.y, want.count, want.in_set, want.shade),
            $sformatf("got x=%0d y=%0d count=%0d in_set=%0d shade=%0d",
                      got.x, got.y, got.count, got.in_set, got.shade)});
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("mandelbrot_escape_time_pixel_top_tb: done, errors");
    $finish;
  end

  initial begin
    plan_row_t        row;
    pixel_result_t    typed;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    tx_gaps        = 1'b1;
    rx_gaps        = 1'b1;
    rx_hold_req    = 1'b0;
    mismatch_count = 0;
    view_re        = CENTER_RE_RST;
    view_im        = CENTER_IM_RST;
    view_step      = PIXEL_STEP_RST;
    view_limit     = ESCAPE_LIMIT_RST;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_REG) begin
        drain_results();
        write_reg(row.idx, row.value);
      end else begin
        typed.x      = row.px;
        typed.y      = row.py;
        typed.count  = row.count;
        typed.in_set = row.in_set;
        typed.shade  = row.shade;
        send_pixel(row.px, row.py, row.known, typed);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      tx_gaps = (ph != 5 && ph != PHASES - 1);
      rx_gaps = tx_gaps;
      randomize_view();
      // Long output stall while pixels keep coming: the engine backs up.
      if (ph == 2) rx_hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2) drain_results();
        px = POS_W'($urandom_range(0, 1023));
        if ($urandom_range(0, 9) == 0) py = POS_W'($urandom_range(768, 1023));
        else py = POS_W'($urandom_range(0, 767));
        send_pixel(px, py, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("mandelbrot_escape_time_pixel_top_tb: done, clean");
    end else begin
      $display("mandelbrot_escape_time_pixel_top_tb: done, errors");
    end
    $finish;
  end

endmodule
